/* design/assert_macros.svh */
// assertion helper macros for the interpolator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

/* design/kfci_pkg.sv */
// ----------------------------------------------------------------------------
// kfci_pkg
// shared types and constants of the keyframe curve interpolator
// ----------------------------------------------------------------------------
package kfci_pkg;
	localparam int MAX_KEYS = 16;
	localparam int KIDX_W = $clog2(MAX_KEYS);
	localparam int KCNT_W = $clog2(MAX_KEYS + 1);

	typedef enum logic [2:0] {
		OC_WRITE = 3'd0,
		OC_DEFAULT = 3'd1,
		OC_CLAMP_LO = 3'd2,
		OC_CLAMP_HI = 3'd3,
		OC_INTERP = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		REG_X_SOURCE = 3'd0,
		REG_LOOP_ENABLE = 3'd1,
		REG_OFFSET_X = 3'd2,
		REG_SCALE_X = 3'd3,
		REG_DEFAULT_VALUE = 3'd4,
		REG_KEY_COUNT = 3'd5
	} reg_idx_t;

	localparam logic [1:0] XS_LIFE = 2'd0;
	localparam logic [1:0] XS_AGE = 2'd1;
	localparam logic [1:0] XS_PARAM = 2'd2;
	localparam logic [1:0] XS_SPEED = 2'd3;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

/* design/keyframe_curve_interpolator_unit.sv */
// key write result valid in the cycle after acceptance; evaluation result valid
// once the source, offset, scale, key search and blend steps are done (life fraction,
// loop wrap and interpolation each use the shared serial divider)
// one transaction at a time: the next is accepted only after the result is taken
// reset: registers return to defaults (scale_x 1.0); key memory stays undefined
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator_unit
// piecewise linear keyframe curve evaluation over a memory of curve keys
// ----------------------------------------------------------------------------
module keyframe_curve_interpolator_unit import kfci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [3:0]         key_index,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] key_y_low,
	input  logic signed [31:0] key_y_high,
	input  logic [30:0]        age,
	input  logic [30:0]        life_left,
	input  logic signed [31:0] param_value,
	input  logic signed [23:0] vel_x,
	input  logic signed [23:0] vel_y,
	input  logic signed [23:0] vel_z,
	input  logic [16:0]        ratio_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [2:0]         outcome,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_SRC, ST_SPD1, ST_SPD2, ST_OFS, ST_SCL, ST_SCL2, ST_CHK,
		ST_RD0, ST_RDL, ST_LOOPDIV, ST_LOOPFIX, ST_SRCH, ST_SRCHW, ST_BL_RD,
		ST_BL_MUL, ST_BL_ADD, ST_IDIV, ST_FMUL, ST_FADD, ST_OUT
	} state_t;

	state_t state_q;
	logic [1:0] x_source_q;
	logic loop_enable_q;
	logic signed [31:0] offset_x_q, scale_x_q, default_value_q;
	logic [4:0] key_count_q;

	logic signed [31:0] kx_mem [MAX_KEYS];
	logic signed [31:0] ylo_mem [MAX_KEYS];
	logic signed [31:0] yhi_mem [MAX_KEYS];
	logic [KIDX_W-1:0] rd_addr;
	logic signed [31:0] kx_rd_q, ylo_rd_q, yhi_rd_q;

	logic [30:0] age_q, life_q;
	logic signed [31:0] param_q;
	logic signed [23:0] vx_q, vy_q, vz_q;
	logic [16:0] ratio_q;

	logic signed [65:0] x_q, acc_q;
	logic signed [31:0] bx_q, px_q, y0_q, y1_q, val_q;
	logic [KCNT_W-1:0] n_q;
	logic [KIDX_W:0] idx_q;
	logic [1:0] bl_q;
	logic [2:0] oc_q;
	logic out_v_q;

	// shared restoring divider: unsigned magnitude, sign fixed after
	logic [63:0] dv_num_q, dv_quo_q;
	logic [64:0] dv_rem_q;
	logic [63:0] dv_den_q;
	logic [6:0] dv_cnt_q;
	logic dv_negr_q;
	logic [64:0] dv_trial;
	assign dv_trial = {dv_rem_q[63:0], dv_num_q[63]} - {1'b0, dv_den_q};

	logic [KCNT_W-1:0] n_cl;
	assign n_cl = (key_count_q > 5'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : KCNT_W'(key_count_q);

	logic signed [33:0] diff_y;
	logic signed [51:0] blend_p;
	assign diff_y = 34'(yhi_rd_q) - 34'(ylo_rd_q);
	assign blend_p = 52'(diff_y) * $signed({1'b0, ratio_q});

	assign in_ready = (state_q == ST_IDLE) && !out_v_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;
	assign value = val_q;
	assign outcome = oc_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && !req_type && 32'(key_index) < MAX_KEYS) begin
			kx_mem[KIDX_W'(key_index)] <= key_x;
			ylo_mem[KIDX_W'(key_index)] <= key_y_low;
			yhi_mem[KIDX_W'(key_index)] <= key_y_high;
		end
		kx_rd_q <= kx_mem[rd_addr];
		ylo_rd_q <= ylo_mem[rd_addr];
		yhi_rd_q <= yhi_mem[rd_addr];
	end

	always_comb begin
		rd_addr = idx_q[KIDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_source_q <= XS_LIFE;
			loop_enable_q <= 1'b0;
			offset_x_q <= '0;
			scale_x_q <= 32'sd65536;
			default_value_q <= '0;
			key_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_SOURCE: x_source_q <= cfg_data[1:0];
				REG_LOOP_ENABLE: loop_enable_q <= cfg_data[0];
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_SCALE_X: scale_x_q <= cfg_data;
				REG_DEFAULT_VALUE: default_value_q <= cfg_data;
				REG_KEY_COUNT: key_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			dv_cnt_q <= '0;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			if (dv_cnt_q != 0) begin
				if (!dv_trial[64]) begin
					dv_rem_q <= dv_trial;
					dv_quo_q <= {dv_quo_q[62:0], 1'b1};
				end else begin
					dv_rem_q <= {dv_rem_q[63:0], dv_num_q[63]};
					dv_quo_q <= {dv_quo_q[62:0], 1'b0};
				end
				dv_num_q <= {dv_num_q[62:0], 1'b0};
				dv_cnt_q <= dv_cnt_q - 7'd1;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					age_q <= age; life_q <= life_left; param_q <= param_value;
					vx_q <= vel_x; vy_q <= vel_y; vz_q <= vel_z;
					ratio_q <= (ratio_y > 17'd65536) ? 17'd65536 : ratio_y;
					n_q <= n_cl;
					if (!req_type) begin
						val_q <= '0; oc_q <= OC_WRITE; out_v_q <= 1'b1;
					end else state_q <= ST_SRC;
				end
				ST_SRC: begin
					unique case (x_source_q)
						XS_LIFE: begin
							x_q <= '0;
							if (({1'b0, age_q} + {1'b0, life_q}) != 0) begin
								dv_num_q <= {17'd0, age_q, 16'd0};
								dv_den_q <= 64'({1'b0, age_q} + {1'b0, life_q});
								dv_rem_q <= '0; dv_quo_q <= '0; dv_cnt_q <= 7'd64;
								dv_negr_q <= 1'b0;
							end
							state_q <= ST_SPD2;
						end
						XS_AGE: begin x_q <= 66'({1'b0, age_q}); state_q <= ST_OFS; end
						XS_PARAM: begin x_q <= 66'(param_q); state_q <= ST_OFS; end
						default: begin
							acc_q <= 66'(vx_q * vx_q) + 66'(vy_q * vy_q);
							state_q <= ST_SPD1;
						end
					endcase
				end
				ST_SPD1: begin
					x_q <= 66'(sat32((acc_q + 66'(vz_q * vz_q)) >>> 16));
					state_q <= ST_OFS;
				end
				ST_SPD2: if (dv_cnt_q == 0) begin
					if (({1'b0, age_q} + {1'b0, life_q}) != 0) x_q <= 66'(dv_quo_q);
					state_q <= ST_OFS;
				end
				ST_OFS: begin x_q <= 66'(sat32(x_q + 66'(offset_x_q))); state_q <= ST_SCL; end
				ST_SCL: begin
					acc_q <= 66'($signed(x_q[31:0]) * scale_x_q);
					state_q <= ST_SCL2;
				end
				ST_SCL2: begin x_q <= 66'(sat32(acc_q >>> 16)); state_q <= ST_CHK; end
				ST_CHK: begin
					if (n_q == 0) begin
						val_q <= default_value_q; oc_q <= OC_DEFAULT; state_q <= ST_OUT;
					end else if (loop_enable_q && n_q < 2) begin
						idx_q <= '0; oc_q <= OC_CLAMP_LO; bl_q <= 2'd0; state_q <= ST_BL_RD;
					end else if (loop_enable_q) begin
						idx_q <= '0; state_q <= ST_RD0;
					end else begin
						idx_q <= '0; state_q <= ST_SRCHW;
					end
				end
				ST_RD0: begin idx_q <= (KIDX_W+1)'(n_q - 1'b1); state_q <= ST_RDL; end
				ST_RDL: begin
					bx_q <= kx_rd_q;
					state_q <= ST_LOOPDIV;
				end
				ST_LOOPDIV: begin
					if (kx_rd_q == 0) begin
						x_q <= 66'(bx_q); idx_q <= '0; state_q <= ST_SRCHW;
					end else begin
						acc_q <= x_q - 66'(bx_q);
						px_q <= kx_rd_q;
						dv_num_q <= ((x_q - 66'(bx_q)) < 0) ? 64'(66'(bx_q) - x_q)
							: 64'(x_q - 66'(bx_q));
						dv_den_q <= kx_rd_q[31] ? 64'(-66'(kx_rd_q)) : 64'(kx_rd_q);
						dv_rem_q <= '0; dv_quo_q <= '0; dv_cnt_q <= 7'd64;
						dv_negr_q <= (x_q - 66'(bx_q)) < 0;
						state_q <= ST_LOOPFIX;
					end
				end
				ST_LOOPFIX: if (dv_cnt_q == 0) begin
					logic signed [65:0] rm;
					rm = dv_negr_q ? -66'(dv_rem_q[63:0]) : 66'(dv_rem_q[63:0]);
					if (rm != 0 && ((rm < 0) != px_q[31])) rm = rm + 66'(px_q);
					x_q <= 66'(sat32(66'(bx_q) + rm));
					idx_q <= '0;
					state_q <= ST_SRCHW;
				end
				ST_SRCHW: state_q <= ST_SRCH;
				ST_SRCH: begin
					if (66'(kx_rd_q) > x_q) begin
						if (idx_q == 0) begin
							oc_q <= OC_CLAMP_LO; bl_q <= 2'd0; state_q <= ST_BL_RD;
						end else begin
							oc_q <= OC_INTERP; px_q <= '0; bx_q <= kx_rd_q;
							idx_q <= idx_q - 1'b1; bl_q <= 2'd1; state_q <= ST_BL_RD;
						end
					end else if (idx_q + 1'b1 == (KIDX_W+1)'(n_q)) begin
						oc_q <= OC_CLAMP_HI; bl_q <= 2'd0; state_q <= ST_BL_RD;
					end else begin
						idx_q <= idx_q + 1'b1; state_q <= ST_SRCHW;
					end
				end
				ST_BL_RD: state_q <= ST_BL_MUL;
				ST_BL_MUL: begin
					if (bl_q == 2'd1) px_q <= kx_rd_q;
					acc_q <= 66'(blend_p);
					state_q <= ST_BL_ADD;
				end
				ST_BL_ADD: begin
					logic signed [31:0] cur_y;
					cur_y = sat32(66'(ylo_rd_q) + (acc_q >>> 16));
					unique case (bl_q)
						2'd0: begin val_q <= cur_y; state_q <= ST_OUT; end
						2'd1: begin
							y0_q <= cur_y; idx_q <= idx_q + 1'b1; bl_q <= 2'd2;
							state_q <= ST_BL_RD;
						end
						default: begin
							y1_q <= cur_y;
							if (66'(bx_q) - 66'(px_q) == 0) begin
								acc_q <= '0; state_q <= ST_FMUL;
							end else begin
								dv_num_q <= 64'((x_q - 66'(px_q)) <<< 16);
								dv_den_q <= 64'(66'(bx_q) - 66'(px_q));
								dv_rem_q <= '0; dv_quo_q <= '0; dv_cnt_q <= 7'd64;
								state_q <= ST_IDIV;
							end
						end
					endcase
				end
				ST_IDIV: if (dv_cnt_q == 0) begin
					acc_q <= 66'(dv_quo_q);
					state_q <= ST_FMUL;
				end
				ST_FMUL: begin
					acc_q <= 66'($signed({1'b0, acc_q[16:0]}) * (66'(y1_q) - 66'(y0_q)));
					state_q <= ST_FADD;
				end
				ST_FADD: begin
					val_q <= sat32(66'(y0_q) + (acc_q >>> 16));
					state_q <= ST_OUT;
				end
				ST_OUT: begin out_v_q <= 1'b1; state_q <= ST_IDLE; end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* design/kfci_checker.sv */
// ----------------------------------------------------------------------------
// kfci_checker
// port-level checks of the keyframe curve interpolator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module kfci_checker import kfci_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic req_type,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] value,
	input logic [2:0] outcome
);
	`CHK_IMPL(a_out_hold, clk, arst_n, out_valid && !out_ready, ##1 out_valid && $stable(value))
	`CHK_IMPL(a_no_in_while_out, clk, arst_n, out_valid, !in_ready)
	`CHK_NEXT(a_write_done, clk, arst_n, in_valid && in_ready && !req_type,
		out_valid && outcome == OC_WRITE && value == 0)
	`CHK_IMPL(a_oc_range, clk, arst_n, out_valid, outcome <= OC_INTERP)
endmodule

bind keyframe_curve_interpolator_unit kfci_checker u_kfci_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.req_type(req_type), .out_valid(out_valid), .out_ready(out_ready),
	.value(value), .outcome(outcome)
);
